/* hw/rtl/cdiv_pkg.sv */
// shared constants and types for the complex divider
package cdiv_pkg;

	localparam int FIELD_BITS   = 32;
	localparam int WORD_BITS_DF = 32;
	localparam int FRAC_BITS_DF = 16;

	// sideband that travels with each transaction down the pipeline
	typedef struct packed {
		logic valid;
		logic zero;
		logic neg_re;
		logic neg_im;
	} cdiv_side_t;

endpackage

/* hw/rtl/complex_divider_unit.sv */
// complex divider top level: front end, division cell chain, saturation
// start travels to strobe through the front-end stage registers, every cell of the chain and the output register
// throughput: one transaction per cycle, one division step per cell in the chain
// busy never rises, the pipeline has no stall and the receiver cannot hold results off
// reset: arst_n clears every valid bit at once, payload registers are not reset
module complex_divider_unit #(
	parameter int WORD_BITS = cdiv_pkg::WORD_BITS_DF,
	parameter int FRAC_BITS = cdiv_pkg::FRAC_BITS_DF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [cdiv_pkg::FIELD_BITS-1:0] dividend_re,
	input  logic signed [cdiv_pkg::FIELD_BITS-1:0] dividend_im,
	input  logic signed [cdiv_pkg::FIELD_BITS-1:0] divisor_re,
	input  logic signed [cdiv_pkg::FIELD_BITS-1:0] divisor_im,
	output logic                                   strobe,
	output logic signed [cdiv_pkg::FIELD_BITS-1:0] quotient_re,
	output logic signed [cdiv_pkg::FIELD_BITS-1:0] quotient_im,
	output logic                                   zero_divisor,
	output logic                                   overflow
);

	localparam int W   = WORD_BITS;
	localparam int MB  = 2 * WORD_BITS;          // numerator, norm and remainder width
	localparam int DW  = MB + FRAC_BITS;         // scaled dividend, one cell per bit
	localparam int QW  = WORD_BITS + 1;          // kept quotient bits, rest is sticky
	localparam int LAT = DW + 4;
	localparam logic [QW-1:0] HALF = QW'(1) << (W - 1);

	// the chain never stalls, so a new transaction is taken every cycle
	assign busy = 1'b0;

	cdiv_pkg::cdiv_side_t side_s3;
	logic [MB-1:0]        num_re_s3, num_im_s3, den_s3;

	cdiv_front #(.WORD_BITS(WORD_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.dividend_re (dividend_re),
		.dividend_im (dividend_im),
		.divisor_re  (divisor_re),
		.divisor_im  (divisor_im),
		.side_s3     (side_s3),
		.num_re_s3   (num_re_s3),
		.num_im_s3   (num_im_s3),
		.den_s3      (den_s3)
	);

	// links between cells, index 0 feeds the first cell
	cdiv_pkg::cdiv_side_t side_c   [0:DW];
	logic [MB-1:0]        den_c    [0:DW];
	logic [DW-1:0]        dvd_re_c [0:DW];
	logic [DW-1:0]        dvd_im_c [0:DW];
	logic [MB-1:0]        rem_re_c [0:DW];
	logic [MB-1:0]        rem_im_c [0:DW];
	logic [QW-1:0]        q_re_c   [0:DW];
	logic [QW-1:0]        q_im_c   [0:DW];
	logic                 big_re_c [0:DW];
	logic                 big_im_c [0:DW];

	// numerator scaled by 2^frac, streamed msb first through the chain
	assign side_c[0]   = side_s3;
	assign den_c[0]    = den_s3;
	assign dvd_re_c[0] = DW'(num_re_s3) << FRAC_BITS;
	assign dvd_im_c[0] = DW'(num_im_s3) << FRAC_BITS;
	assign rem_re_c[0] = '0;
	assign rem_im_c[0] = '0;
	assign q_re_c[0]   = '0;
	assign q_im_c[0]   = '0;
	assign big_re_c[0] = 1'b0;
	assign big_im_c[0] = 1'b0;

	for (genvar k = 0; k < DW; k++) begin : g_cell
		cdiv_cell #(.MB(MB), .DW(DW), .QW(QW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.side_i   (side_c[k]),
			.den_i    (den_c[k]),
			.dvd_re_i (dvd_re_c[k]),
			.dvd_im_i (dvd_im_c[k]),
			.rem_re_i (rem_re_c[k]),
			.rem_im_i (rem_im_c[k]),
			.q_re_i   (q_re_c[k]),
			.q_im_i   (q_im_c[k]),
			.big_re_i (big_re_c[k]),
			.big_im_i (big_im_c[k]),
			.side_q   (side_c[k+1]),
			.den_q    (den_c[k+1]),
			.dvd_re_q (dvd_re_c[k+1]),
			.dvd_im_q (dvd_im_c[k+1]),
			.rem_re_q (rem_re_c[k+1]),
			.rem_im_q (rem_im_c[k+1]),
			.q_re_q   (q_re_c[k+1]),
			.q_im_q   (q_im_c[k+1]),
			.big_re_q (big_re_c[k+1]),
			.big_im_q (big_im_c[k+1])
		);
	end

	// saturation to the word range
	cdiv_pkg::cdiv_side_t side_e;
	logic [QW-1:0]        q_re_e, q_im_e, mag_re, mag_im, res_re, res_im;
	logic                 ovf_re, ovf_im;

	assign side_e = side_c[DW];
	assign q_re_e = q_re_c[DW];
	assign q_im_e = q_im_c[DW];

	always_comb begin
		if (side_e.neg_re) begin
			ovf_re = big_re_c[DW] | (q_re_e > HALF);
			mag_re = ovf_re ? HALF : q_re_e;
			res_re = ~mag_re + 1'b1;
		end else begin
			ovf_re = big_re_c[DW] | (q_re_e > HALF - 1'b1);
			mag_re = ovf_re ? HALF - 1'b1 : q_re_e;
			res_re = mag_re;
		end
		if (side_e.neg_im) begin
			ovf_im = big_im_c[DW] | (q_im_e > HALF);
			mag_im = ovf_im ? HALF : q_im_e;
			res_im = ~mag_im + 1'b1;
		end else begin
			ovf_im = big_im_c[DW] | (q_im_e > HALF - 1'b1);
			mag_im = ovf_im ? HALF - 1'b1 : q_im_e;
			res_im = mag_im;
		end
	end

	// output register, strobe is high for one cycle per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= side_e.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (side_e.zero) begin
			quotient_re <= '0;
			quotient_im <= '0;
			overflow    <= 1'b0;
		end else begin
			quotient_re <= cdiv_pkg::FIELD_BITS'(res_re[W-1:0]);
			quotient_im <= cdiv_pkg::FIELD_BITS'(res_im[W-1:0]);
			overflow    <= ovf_re | ovf_im;
		end
		zero_divisor <= side_e.zero;
	end

	// every accepted transaction produces a result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT strobe)
		else $error("result strobe missing after fixed latency");

	// a zero divisor gives zero parts and no overflow
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && zero_divisor) |-> (quotient_re == '0 && quotient_im == '0 && !overflow))
		else $error("zero divisor result not cleared");

	// no strobe without a transaction taken at the matching earlier edge
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> $past(start, LAT))
		else $error("strobe without a transaction");

endmodule

/* hw/rtl/cdiv_front.sv */
// front end: magnitudes, cross products, numerators and squared norm
module cdiv_front #(
	parameter int WORD_BITS = cdiv_pkg::WORD_BITS_DF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [cdiv_pkg::FIELD_BITS-1:0] dividend_re,
	input  logic signed [cdiv_pkg::FIELD_BITS-1:0] dividend_im,
	input  logic signed [cdiv_pkg::FIELD_BITS-1:0] divisor_re,
	input  logic signed [cdiv_pkg::FIELD_BITS-1:0] divisor_im,
	output cdiv_pkg::cdiv_side_t                side_s3,
	output logic [2*WORD_BITS-1:0]              num_re_s3,
	output logic [2*WORD_BITS-1:0]              num_im_s3,
	output logic [2*WORD_BITS-1:0]              den_s3
);

	localparam int W  = WORD_BITS;
	localparam int MB = 2 * WORD_BITS;

	logic [W-1:0] va, vb, vc, vd;
	logic [W-1:0] ma, mb, mc, md;

	assign va = dividend_re[W-1:0];
	assign vb = dividend_im[W-1:0];
	assign vc = divisor_re[W-1:0];
	assign vd = divisor_im[W-1:0];
	assign ma = va[W-1] ? (~va + 1'b1) : va;
	assign mb = vb[W-1] ? (~vb + 1'b1) : vb;
	assign mc = vc[W-1] ? (~vc + 1'b1) : vc;
	assign md = vd[W-1] ? (~vd + 1'b1) : vd;

	// stage 1: magnitudes and signs
	logic         valid_s1;
	logic [W-1:0] ma_s1, mb_s1, mc_s1, md_s1;
	logic         sa_s1, sb_s1, sc_s1, sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1 <= ma;
		mb_s1 <= mb;
		mc_s1 <= mc;
		md_s1 <= md;
		sa_s1 <= va[W-1];
		sb_s1 <= vb[W-1];
		sc_s1 <= vc[W-1];
		sd_s1 <= vd[W-1];
	end

	// stage 2: products
	logic          valid_s2;
	logic [MB-1:0] ac_s2, bd_s2, bc_s2, ad_s2, cc_s2, dd_s2;
	logic          sre1_s2, sre2_s2, sim1_s2, sim2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ac_s2   <= MB'(ma_s1) * MB'(mc_s1);
		bd_s2   <= MB'(mb_s1) * MB'(md_s1);
		bc_s2   <= MB'(mb_s1) * MB'(mc_s1);
		ad_s2   <= MB'(ma_s1) * MB'(md_s1);
		cc_s2   <= MB'(mc_s1) * MB'(mc_s1);
		dd_s2   <= MB'(md_s1) * MB'(md_s1);
		sre1_s2 <= sa_s1 ^ sc_s1;
		sre2_s2 <= sb_s1 ^ sd_s1;
		sim1_s2 <= sb_s1 ^ sc_s1;
		sim2_s2 <= ~(sa_s1 ^ sd_s1);
	end

	// stage 3: signed-magnitude sums and norm
	logic [MB-1:0] nre, nim, den;
	logic          sre, sim;

	always_comb begin
		if (sre1_s2 == sre2_s2) begin
			nre = ac_s2 + bd_s2;
			sre = sre1_s2;
		end else if (ac_s2 >= bd_s2) begin
			nre = ac_s2 - bd_s2;
			sre = sre1_s2;
		end else begin
			nre = bd_s2 - ac_s2;
			sre = sre2_s2;
		end
		if (sim1_s2 == sim2_s2) begin
			nim = bc_s2 + ad_s2;
			sim = sim1_s2;
		end else if (bc_s2 >= ad_s2) begin
			nim = bc_s2 - ad_s2;
			sim = sim1_s2;
		end else begin
			nim = ad_s2 - bc_s2;
			sim = sim2_s2;
		end
		den = cc_s2 + dd_s2;
	end

	logic valid_s3, zero_s3, neg_re_s3, neg_im_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		zero_s3   <= (den == '0);
		neg_re_s3 <= sre & (nre != '0);
		neg_im_s3 <= sim & (nim != '0);
		num_re_s3 <= nre;
		num_im_s3 <= nim;
		den_s3    <= den;
	end

	assign side_s3 = '{valid: valid_s3, zero: zero_s3, neg_re: neg_re_s3,
		neg_im: neg_im_s3};

endmodule

/* hw/rtl/cdiv_cell.sv */
// one restoring division step for both quotient parts
module cdiv_cell #(
	parameter int MB = 64,
	parameter int DW = 80,
	parameter int QW = 33
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cdiv_pkg::cdiv_side_t side_i,
	input  logic [MB-1:0]        den_i,
	input  logic [DW-1:0]        dvd_re_i,
	input  logic [DW-1:0]        dvd_im_i,
	input  logic [MB-1:0]        rem_re_i,
	input  logic [MB-1:0]        rem_im_i,
	input  logic [QW-1:0]        q_re_i,
	input  logic [QW-1:0]        q_im_i,
	input  logic                 big_re_i,
	input  logic                 big_im_i,
	output cdiv_pkg::cdiv_side_t side_q,
	output logic [MB-1:0]        den_q,
	output logic [DW-1:0]        dvd_re_q,
	output logic [DW-1:0]        dvd_im_q,
	output logic [MB-1:0]        rem_re_q,
	output logic [MB-1:0]        rem_im_q,
	output logic [QW-1:0]        q_re_q,
	output logic [QW-1:0]        q_im_q,
	output logic                 big_re_q,
	output logic                 big_im_q
);

	logic [MB:0] sh_re, sh_im, df_re, df_im;
	logic        qb_re, qb_im;
	logic        valid_q, zero_q, neg_re_q, neg_im_q;

	assign sh_re = {rem_re_i, dvd_re_i[DW-1]};
	assign sh_im = {rem_im_i, dvd_im_i[DW-1]};
	assign df_re = sh_re - {1'b0, den_i};
	assign df_im = sh_im - {1'b0, den_i};
	assign qb_re = (sh_re >= {1'b0, den_i});
	assign qb_im = (sh_im >= {1'b0, den_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= side_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_q   <= side_i.zero;
		neg_re_q <= side_i.neg_re;
		neg_im_q <= side_i.neg_im;
		den_q    <= den_i;
		dvd_re_q <= {dvd_re_i[DW-2:0], 1'b0};
		dvd_im_q <= {dvd_im_i[DW-2:0], 1'b0};
		rem_re_q <= qb_re ? df_re[MB-1:0] : sh_re[MB-1:0];
		rem_im_q <= qb_im ? df_im[MB-1:0] : sh_im[MB-1:0];
		q_re_q   <= {q_re_i[QW-2:0], qb_re};
		q_im_q   <= {q_im_i[QW-2:0], qb_im};
		// sticky: a quotient bit pushed out the top means far out of range
		big_re_q <= big_re_i | q_re_i[QW-1];
		big_im_q <= big_im_i | q_im_i[QW-1];
	end

	assign side_q = '{valid: valid_q, zero: zero_q, neg_re: neg_re_q, neg_im: neg_im_q};

endmodule
